>>> rtl/bfsp_pkg.sv
// Shared types, constants and helpers for the shortest-path unit.
package bfsp_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int MAX_EDGES    = 256;
  localparam int EDGE_AW      = $clog2(MAX_EDGES);
  localparam int EDGE_CW      = $clog2(MAX_EDGES + 1);
  localparam int EDGE_W       = 44;
  localparam int EXACT_W      = 48;

  localparam logic [31:0]        COST_INF  = 32'h7FFF_FFFF;
  localparam logic [31:0]        COST_MIN  = 32'h8000_0000;
  localparam logic [EXACT_W-1:0] EXACT_INF = {1'b0, {(EXACT_W-1){1'b1}}};
  localparam logic [EXACT_W-1:0] EXACT_MIN32 =
    {{(EXACT_W-32){1'b1}}, 32'h8000_0000};
  localparam logic [6:0]         PRED_NONE = 7'h7F;

  localparam logic CFG_VERTEX_COUNT  = 1'b0;
  localparam logic CFG_SOURCE_VERTEX = 1'b1;
  localparam logic MODE_LOAD         = 1'b0;
  localparam logic MODE_RUN          = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [5:0]  from_vertex;
    logic [5:0]  to_vertex;
    logic [31:0] weight;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  vertex;
    logic [31:0] distance;
    logic [6:0]  predecessor;
    logic        negative_cycle;
    logic        saturated;
    logic        edges_dropped;
    logic        last;
  } out_item_t;

  typedef enum logic [4:0] {
    S_IDLE, S_INIT,
    S_SE_ADDR, S_SE_EDGE, S_SE_COST, S_SV_RD, S_SV_UPD,
    S_XE_ADDR, S_XE_EDGE, S_XE_FROM, S_XE_TO, S_XE_END,
    S_SAT_RD, S_SAT_CHK,
    S_OUT_RD, S_OUT_LD, S_OUT_WAIT, S_FINISH
  } state_t;

  // INF absorbs; otherwise the sum is clamped into [COST_MIN, COST_INF]
  function automatic logic [31:0] cost_sum(input logic [31:0] a, input logic [31:0] b);
    logic signed [32:0] s;
    s = $signed({a[31], a}) + $signed({b[31], b});
    if (a == COST_INF || b == COST_INF) return COST_INF;
    else if (s > $signed({1'b0, COST_INF})) return COST_INF;
    else if (s < $signed({1'b1, COST_MIN})) return COST_MIN;
    else return s[31:0];
  endfunction

endpackage

>>> rtl/bfsp_ram.sv
// Generic single-write, single-read RAM with registered, enabled read.
module bfsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/bellman_ford_shortest_paths_unit.sv
// Bellman-Ford single-source shortest-path unit: edge store, sequencer and results.
//
// Input channel (in_valid/in_ready/in_data): a mode 0 transaction stores one
// directed edge; an edge is dropped (sticky flag) if the store is
// full or an endpoint is not below the vertex count. A mode 1 transaction runs
// the search from the source vertex and then emits one result per vertex,
// ascending, on the output channel (out_valid/out_ready/out_data), last set on
// the final one. After the final result the edge store and drop flag are cleared.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 vertex count,
// 1 source vertex) in the same cycle; write only while the unit is idle.
// Order of a run: init of all V vertices, then saturating rounds and exact
// rounds (at most V-1 rounds of each plus one check round), then a saturation
// scan unless a negative cycle was found, then emission and clearing of the store.
// All of it runs over one compare/add datapath and single-read memories.
// in_ready is low from the run transaction until the store is cleared.
// The receiver may stall freely: each result holds in the output register.
// Reset (rst, synchronous) empties the store, clears the drop flag and both
// registers; memory contents are not cleared.
module bellman_ford_shortest_paths_unit
  import bfsp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  logic      cfg_index,
  input  logic [6:0] cfg_data
);

  state_t state, state_next;

  logic [6:0]         num_vertices;
  logic [5:0]         source_vertex;
  logic [EDGE_CW-1:0] edge_fill;
  logic               drop_flag;
  logic [5:0]         v_idx;
  logic [EDGE_CW-1:0] e_idx;
  logic [5:0]         round;
  logic               changed;
  logic               any_best;
  logic [31:0]        best;
  logic [5:0]         best_from;
  logic [EXACT_W-1:0] f_exact;
  logic               xcheck;
  logic               neg;
  logic               sat;
  out_item_t          out_reg;

  // memory ports
  logic               edge_we, edge_re;
  logic [EDGE_W-1:0]  edge_q;
  logic               ds_we, ds_re;
  logic [5:0]         ds_raddr;
  logic [31:0]        ds_wdata, ds_q;
  logic               pr_re;
  logic [6:0]         pr_wdata, pr_q;
  logic               dx_we, dx_re;
  logic [5:0]         dx_raddr, dx_waddr;
  logic [EXACT_W-1:0] dx_wdata, dx_q;

  logic [6:0]  nv;
  logic        run_ok;
  logic        v_last;
  logic        e_end;
  logic [5:0]  e_from, e_to;
  logic [31:0] e_w;
  logic        e_live;
  logic [31:0] cost;
  logic [EXACT_W-1:0] x_sum;
  logic        sv_improve, xe_improve;
  logic        more_rounds;
  logic        in_acc, load_ok;

  assign nv       = (num_vertices > 7'(MAX_VERTICES)) ? 7'(MAX_VERTICES) : num_vertices;
  assign run_ok   = (nv != 7'd0) && ({1'b0, source_vertex} < nv);
  assign v_last   = ({1'b0, v_idx} == nv - 7'd1);
  assign e_end    = (e_idx == edge_fill);
  assign e_from   = edge_q[43:38];
  assign e_to     = edge_q[37:32];
  assign e_w      = edge_q[31:0];
  assign e_live   = ({1'b0, e_from} < nv) && ({1'b0, e_to} < nv);
  assign cost     = cost_sum(ds_q, e_w);
  assign x_sum    = f_exact + {{(EXACT_W-32){e_w[31]}}, e_w};
  assign sv_improve = any_best && ($signed(best) < $signed(ds_q));
  assign xe_improve = $signed(x_sum) < $signed(dx_q);
  // another round runs if r+1 < nv after the increment
  assign more_rounds = ({2'b0, round} + 8'd2) < {1'b0, nv};
  assign in_acc   = in_valid && in_ready;
  assign load_ok  = (edge_fill < EDGE_CW'(MAX_EDGES)) &&
                    ({1'b0, in_data.from_vertex} < nv) && ({1'b0, in_data.to_vertex} < nv);

  bfsp_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk, .we(edge_we), .waddr(edge_fill[EDGE_AW-1:0]),
    .wdata({in_data.from_vertex, in_data.to_vertex, in_data.weight}),
    .re(edge_re), .raddr(e_idx[EDGE_AW-1:0]), .rdata(edge_q)
  );

  bfsp_ram #(.WIDTH(32), .DEPTH(MAX_VERTICES)) u_dist_ram (
    .clk, .we(ds_we), .waddr(v_idx), .wdata(ds_wdata),
    .re(ds_re), .raddr(ds_raddr), .rdata(ds_q)
  );

  bfsp_ram #(.WIDTH(7), .DEPTH(MAX_VERTICES)) u_pred_ram (
    .clk, .we(ds_we), .waddr(v_idx), .wdata(pr_wdata),
    .re(pr_re), .raddr(v_idx), .rdata(pr_q)
  );

  bfsp_ram #(.WIDTH(EXACT_W), .DEPTH(MAX_VERTICES)) u_exact_ram (
    .clk, .we(dx_we), .waddr(dx_waddr), .wdata(dx_wdata),
    .re(dx_re), .raddr(dx_raddr), .rdata(dx_q)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:
        if (in_acc && in_data.mode != MODE_LOAD) begin
          state_next = (nv == 7'd0) ? S_FINISH : S_INIT;
        end
      S_INIT:
        if (v_last) begin
          if (!run_ok) state_next = S_OUT_RD;
          else if (nv > 7'd1) state_next = S_SE_ADDR;
          else state_next = S_XE_ADDR;
        end
      S_SE_ADDR: state_next = e_end ? S_SV_RD : S_SE_EDGE;
      S_SE_EDGE: state_next = (e_live && e_to == v_idx) ? S_SE_COST : S_SE_ADDR;
      S_SE_COST: state_next = S_SE_ADDR;
      S_SV_RD:   state_next = S_SV_UPD;
      S_SV_UPD:
        if (!v_last || ((changed || sv_improve) && more_rounds)) state_next = S_SE_ADDR;
        else state_next = S_XE_ADDR;
      S_XE_ADDR: state_next = e_end ? S_XE_END : S_XE_EDGE;
      S_XE_EDGE: state_next = (e_live && e_w != COST_INF) ? S_XE_FROM : S_XE_ADDR;
      S_XE_FROM: state_next = (dx_q == EXACT_INF) ? S_XE_ADDR : S_XE_TO;
      S_XE_TO:   state_next = S_XE_ADDR;
      S_XE_END:
        if (xcheck) state_next = changed ? S_OUT_RD : S_SAT_RD;
        else state_next = S_XE_ADDR;
      S_SAT_RD:  state_next = S_SAT_CHK;
      S_SAT_CHK: state_next = v_last ? S_OUT_RD : S_SAT_RD;
      S_OUT_RD:  state_next = S_OUT_LD;
      S_OUT_LD:  state_next = S_OUT_WAIT;
      S_OUT_WAIT:
        if (out_ready) state_next = v_last ? S_FINISH : S_OUT_RD;
      S_FINISH:  state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // handshakes and memory controls
  always_comb begin
    in_ready = 1'b0;
    out_valid = 1'b0;
    edge_we = 1'b0;
    edge_re = 1'b0;
    ds_we = 1'b0;
    ds_re = 1'b0;
    ds_raddr = v_idx;
    ds_wdata = best;
    pr_re = 1'b0;
    pr_wdata = {1'b0, best_from};
    dx_we = 1'b0;
    dx_re = 1'b0;
    dx_raddr = v_idx;
    dx_waddr = e_to;
    dx_wdata = x_sum;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        edge_we = in_valid && in_data.mode == MODE_LOAD && load_ok;
      end
      S_INIT: begin
        ds_we = 1'b1;
        ds_wdata = (run_ok && v_idx == source_vertex) ? 32'd0 : COST_INF;
        pr_wdata = PRED_NONE;
        dx_we = 1'b1;
        dx_waddr = v_idx;
        dx_wdata = (run_ok && v_idx == source_vertex) ? '0 : EXACT_INF;
      end
      S_SE_ADDR, S_XE_ADDR: edge_re = !e_end;
      S_SE_EDGE: begin
        ds_re = e_live && e_to == v_idx;
        ds_raddr = e_from;
      end
      S_SV_RD: ds_re = 1'b1;
      S_SV_UPD: ds_we = sv_improve;
      S_XE_EDGE: begin
        dx_re = e_live && e_w != COST_INF;
        dx_raddr = e_from;
      end
      S_XE_FROM: begin
        dx_re = dx_q != EXACT_INF;
        dx_raddr = e_to;
      end
      S_XE_TO: dx_we = xe_improve;
      S_SAT_RD: dx_re = 1'b1;
      S_OUT_RD: begin
        ds_re = 1'b1;
        pr_re = 1'b1;
      end
      S_OUT_WAIT: out_valid = 1'b1;
      S_SE_COST, S_XE_END, S_SAT_CHK, S_OUT_LD, S_FINISH: ;
      default: ;
    endcase
  end

  assign out_data = out_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      num_vertices <= '0;
      source_vertex <= '0;
      edge_fill <= '0;
      drop_flag <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        if (cfg_index == CFG_VERTEX_COUNT) num_vertices <= cfg_data;
        else source_vertex <= cfg_data[5:0];
      end
      if (state == S_IDLE && in_acc && in_data.mode == MODE_LOAD) begin
        if (load_ok) edge_fill <= edge_fill + EDGE_CW'(1);
        else drop_flag <= 1'b1;
      end
      if (state == S_FINISH) begin
        edge_fill <= '0;
        drop_flag <= 1'b0;
      end
    end
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        v_idx <= '0;
        e_idx <= '0;
        round <= '0;
        changed <= 1'b0;
        any_best <= 1'b0;
        neg <= 1'b0;
        sat <= 1'b0;
        xcheck <= (nv <= 7'd1);
      end
      S_INIT:
        if (!v_last) v_idx <= v_idx + 6'd1;
        else v_idx <= '0;
      S_SE_EDGE:
        if (!(e_live && e_to == v_idx)) e_idx <= e_idx + EDGE_CW'(1);
      S_SE_COST: begin
        if (!any_best || $signed(cost) < $signed(best)) begin
          best <= cost;
          best_from <= e_from;
          any_best <= 1'b1;
        end
        e_idx <= e_idx + EDGE_CW'(1);
      end
      S_SV_UPD: begin
        e_idx <= '0;
        any_best <= 1'b0;
        if (!v_last) begin
          v_idx <= v_idx + 6'd1;
          if (sv_improve) changed <= 1'b1;
        end else if ((changed || sv_improve) && more_rounds) begin
          v_idx <= '0;
          round <= round + 6'd1;
          changed <= 1'b0;
        end else begin
          round <= '0;
          changed <= 1'b0;
          xcheck <= 1'b0;
        end
      end
      S_XE_EDGE:
        if (!(e_live && e_w != COST_INF)) e_idx <= e_idx + EDGE_CW'(1);
      S_XE_FROM: begin
        f_exact <= dx_q;
        if (dx_q == EXACT_INF) e_idx <= e_idx + EDGE_CW'(1);
      end
      S_XE_TO: begin
        if (xe_improve) changed <= 1'b1;
        e_idx <= e_idx + EDGE_CW'(1);
      end
      S_XE_END: begin
        e_idx <= '0;
        v_idx <= '0;
        if (xcheck) begin
          neg <= changed;
        end else begin
          round <= round + 6'd1;
          changed <= 1'b0;
          if (!(changed && more_rounds)) xcheck <= 1'b1;
        end
      end
      S_SAT_CHK: begin
        if (dx_q != EXACT_INF && $signed(dx_q) < $signed(EXACT_MIN32)) sat <= 1'b1;
        v_idx <= v_last ? 6'd0 : v_idx + 6'd1;
      end
      S_OUT_LD: begin
        out_reg.vertex <= v_idx;
        out_reg.distance <= ds_q;
        out_reg.predecessor <= pr_q;
        out_reg.negative_cycle <= neg;
        out_reg.saturated <= sat;
        out_reg.edges_dropped <= drop_flag;
        out_reg.last <= v_last;
      end
      S_OUT_WAIT:
        if (out_ready && !v_last) v_idx <= v_idx + 6'd1;
      S_SE_ADDR, S_SV_RD, S_XE_ADDR, S_SAT_RD, S_OUT_RD, S_FINISH: ;
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_busy_when_emitting: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input accepted while a result is pending");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && out_data.last) |=> ##1 (edge_fill == '0 && !drop_flag))
    else $error("edge store not cleared after final result");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    edge_fill <= EDGE_CW'(MAX_EDGES))
    else $error("edge fill beyond store depth");

  a_vertex_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, out_data.vertex} < nv))
    else $error("result vertex out of range");
`endif

endmodule
